>>> src/whitespace_break_normalizer_core_defines.svh
// assertion macros used by the normaliser datapath wbn_dp
// expects clk and rst_n in the including module
`ifndef WHITESPACE_BREAK_NORMALIZER_CORE_DEFINES_SVH
`define WHITESPACE_BREAK_NORMALIZER_CORE_DEFINES_SVH

// same-cycle implication
`define WBN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WBN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/wbn_pkg.sv
// shared types and constants of the whitespace and break normaliser
// used by wbn_dp, wbn_ctrl and whitespace_break_normalizer_core
package wbn_pkg;

    localparam int CNT_W     = 6;
    localparam int BYTE_W    = 8;
    localparam int NUM_CFG   = 7;
    localparam int CFG_IDX_W = 3;
    localparam int PROG_LEN  = 7;

    localparam logic [CNT_W-1:0]  MAX_RUN  = CNT_W'(31);
    localparam logic [BYTE_W-1:0] BRK_BYTE = 8'h0A;
    localparam logic [BYTE_W-1:0] SPC_BYTE = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ESCAPE       = 3'd0,
        REG_DOUBLE_ON    = 3'd1,
        REG_DOUBLE_OFF   = 3'd2,
        REG_COLLAPSE_ON  = 3'd3,
        REG_COLLAPSE_OFF = 3'd4,
        REG_REPLACE_ON   = 3'd5,
        REG_REPLACE_OFF  = 3'd6
    } cfg_idx_t;

    localparam logic [BYTE_W-1:0] CFG_RESET [NUM_CFG] =
        '{8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7};

    typedef enum logic [2:0] {
        CK_NONE,
        CK_DOUBLE_ON,
        CK_DOUBLE_OFF,
        CK_COLLAPSE_ON,
        CK_COLLAPSE_OFF,
        CK_REPLACE_ON,
        CK_REPLACE_OFF
    } code_kind_t;

    typedef enum logic [1:0] {
        BK_BREAK,
        BK_SPACE,
        BK_ESCAPE,
        BK_TEXT
    } byte_kind_t;

    typedef enum logic [1:0] {
        EM_ESCAPE,
        EM_TEXT,
        EM_SPACE,
        EM_RUN
    } emit_sel_t;

    typedef struct packed {
        logic      latch;
        logic      emit;
        emit_sel_t emit_sel;
        logic      pb_inc;
        logic      ps_add;
        logic      pb_clr;
        logic      ps_clr;
        logic      run_load;
        logic      run_brk;
        logic      cnt_dec;
        logic      esc_set;
        logic      esc_clr;
        logic      set_double;
        logic      set_collapse;
        logic      set_replace;
        logic      modes_reset;
        logic      release_hold;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       esc_seen;
        byte_kind_t byte_kind;
        code_kind_t code_kind;
        logic       last;
        logic       pb_zero;
        logic       pb_one;
        logic       ps_zero;
        logic       replace;
        logic       collapse;
        logic       cnt_one;
        logic       emit_ok;
        logic       release_ok;
    } dp_status_t;

endpackage

>>> src/wbn_dp.sv
// datapath: configuration registers, pending counts, modes, hold and output registers
// depends on wbn_pkg and whitespace_break_normalizer_core_defines.svh
`include "whitespace_break_normalizer_core_defines.svh"

module wbn_dp
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [wbn_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [wbn_pkg::BYTE_W-1:0]    cfg_data,
    input  logic [wbn_pkg::BYTE_W-1:0]    in_data,
    input  logic                         in_last,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [wbn_pkg::BYTE_W-1:0]    out_data,
    output logic                         out_last,
    input  wbn_pkg::ctrl_cmd_t           cmd,
    output wbn_pkg::dp_status_t          status
);

    logic [wbn_pkg::BYTE_W-1:0] cfg_reg [wbn_pkg::NUM_CFG];

    logic [wbn_pkg::BYTE_W-1:0] byte_reg;
    logic                       last_reg;
    logic [wbn_pkg::CNT_W-1:0]  ps_reg, ps_next;
    logic [wbn_pkg::CNT_W-1:0]  pb_reg, pb_next;
    logic [wbn_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       run_brk_reg;
    logic                       replace_reg, replace_next;
    logic                       collapse_reg, collapse_next;
    logic                       double_reg, double_next;
    logic                       esc_reg, esc_next;
    logic                       hold_valid_reg, hold_valid_next;
    logic [wbn_pkg::BYTE_W-1:0] hold_byte_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [wbn_pkg::BYTE_W-1:0] out_byte_reg;
    logic                       out_last_reg;

    logic                       out_free;
    logic                       load_out;
    logic [wbn_pkg::BYTE_W-1:0] emit_byte;
    logic [1:0]                 space_step;
    wbn_pkg::byte_kind_t        byte_kind;
    wbn_pkg::code_kind_t        code_kind;

    function automatic logic [wbn_pkg::CNT_W-1:0] sat_add(
        input logic [wbn_pkg::CNT_W-1:0] v,
        input logic [1:0]                a
    );
        logic [wbn_pkg::CNT_W:0] s;
        s = {1'b0, v} + {{(wbn_pkg::CNT_W-1){1'b0}}, a};
        return (s > {1'b0, wbn_pkg::MAX_RUN}) ? wbn_pkg::MAX_RUN : s[wbn_pkg::CNT_W-1:0];
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wbn_pkg::NUM_CFG; i++)
            begin
                cfg_reg[i] <= wbn_pkg::CFG_RESET[i];
            end
        end
        else if (cfg_we && (cfg_addr < wbn_pkg::CFG_IDX_W'(wbn_pkg::NUM_CFG)))
        begin
            cfg_reg[cfg_addr] <= cfg_data;
        end
    end

    // classification of the held byte
    always_comb
    begin
        if (byte_reg == wbn_pkg::BRK_BYTE)
        begin
            byte_kind = wbn_pkg::BK_BREAK;
        end
        else if (byte_reg == wbn_pkg::SPC_BYTE)
        begin
            byte_kind = wbn_pkg::BK_SPACE;
        end
        else if (byte_reg == cfg_reg[wbn_pkg::REG_ESCAPE])
        begin
            byte_kind = wbn_pkg::BK_ESCAPE;
        end
        else
        begin
            byte_kind = wbn_pkg::BK_TEXT;
        end

        if (byte_reg == cfg_reg[wbn_pkg::REG_DOUBLE_ON])
        begin
            code_kind = wbn_pkg::CK_DOUBLE_ON;
        end
        else if (byte_reg == cfg_reg[wbn_pkg::REG_DOUBLE_OFF])
        begin
            code_kind = wbn_pkg::CK_DOUBLE_OFF;
        end
        else if (byte_reg == cfg_reg[wbn_pkg::REG_COLLAPSE_ON])
        begin
            code_kind = wbn_pkg::CK_COLLAPSE_ON;
        end
        else if (byte_reg == cfg_reg[wbn_pkg::REG_COLLAPSE_OFF])
        begin
            code_kind = wbn_pkg::CK_COLLAPSE_OFF;
        end
        else if (byte_reg == cfg_reg[wbn_pkg::REG_REPLACE_ON])
        begin
            code_kind = wbn_pkg::CK_REPLACE_ON;
        end
        else if (byte_reg == cfg_reg[wbn_pkg::REG_REPLACE_OFF])
        begin
            code_kind = wbn_pkg::CK_REPLACE_OFF;
        end
        else
        begin
            code_kind = wbn_pkg::CK_NONE;
        end
    end

    assign out_free   = !out_valid_reg || out_ready;
    assign space_step = double_reg ? 2'd2 : 2'd1;

    always_comb
    begin
        case (cmd.emit_sel)
            wbn_pkg::EM_ESCAPE: emit_byte = cfg_reg[wbn_pkg::REG_ESCAPE];
            wbn_pkg::EM_TEXT:   emit_byte = byte_reg;
            wbn_pkg::EM_SPACE:  emit_byte = wbn_pkg::SPC_BYTE;
            wbn_pkg::EM_RUN:    emit_byte = run_brk_reg ? wbn_pkg::BRK_BYTE : wbn_pkg::SPC_BYTE;
            default:            emit_byte = wbn_pkg::SPC_BYTE;
        endcase
    end

    // next state of counts and modes
    always_comb
    begin
        ps_next       = ps_reg;
        pb_next       = pb_reg;
        cnt_next      = cnt_reg;
        replace_next  = replace_reg;
        collapse_next = collapse_reg;
        double_next   = double_reg;
        esc_next      = esc_reg;

        if (cmd.ps_clr)
        begin
            ps_next = '0;
        end
        else if (cmd.ps_add)
        begin
            ps_next = sat_add(ps_reg, space_step);
        end

        if (cmd.pb_clr)
        begin
            pb_next = '0;
        end
        else if (cmd.pb_inc)
        begin
            pb_next = sat_add(pb_reg, 2'd1);
        end

        if (cmd.run_load)
        begin
            cnt_next = cmd.run_brk ? pb_reg : ps_reg;
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - wbn_pkg::CNT_W'(1);
        end

        if (cmd.set_double)
        begin
            double_next = (code_kind == wbn_pkg::CK_DOUBLE_ON);
        end
        if (cmd.set_collapse)
        begin
            collapse_next = (code_kind == wbn_pkg::CK_COLLAPSE_ON);
        end
        if (cmd.set_replace)
        begin
            replace_next = (code_kind == wbn_pkg::CK_REPLACE_ON);
        end

        if (cmd.esc_clr)
        begin
            esc_next = 1'b0;
        end
        else if (cmd.esc_set)
        begin
            esc_next = 1'b1;
        end

        // end of stream
        if (cmd.modes_reset)
        begin
            ps_next       = '0;
            pb_next       = '0;
            replace_next  = 1'b1;
            collapse_next = 1'b1;
            double_next   = 1'b0;
            esc_next      = 1'b0;
        end
    end

    // hold stage keeps one byte back so the last one of an item can be marked
    always_comb
    begin
        load_out        = (cmd.emit || cmd.release_hold) && hold_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        hold_valid_next = hold_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        if (cmd.emit)
        begin
            hold_valid_next = 1'b1;
        end
        else if (cmd.release_hold)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg         <= '0;
            pb_reg         <= '0;
            cnt_reg        <= '0;
            replace_reg    <= 1'b1;
            collapse_reg   <= 1'b1;
            double_reg     <= 1'b0;
            esc_reg        <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            ps_reg         <= ps_next;
            pb_reg         <= pb_next;
            cnt_reg        <= cnt_next;
            replace_reg    <= replace_next;
            collapse_reg   <= collapse_next;
            double_reg     <= double_next;
            esc_reg        <= esc_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            byte_reg <= in_data;
            last_reg <= in_last;
        end
        if (cmd.run_load)
        begin
            run_brk_reg <= cmd.run_brk;
        end
        if (cmd.emit)
        begin
            hold_byte_reg <= emit_byte;
        end
        if (load_out)
        begin
            out_byte_reg <= hold_byte_reg;
            out_last_reg <= cmd.release_hold;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_byte_reg;
    assign out_last  = out_last_reg;

    assign status.esc_seen   = esc_reg;
    assign status.byte_kind  = byte_kind;
    assign status.code_kind  = code_kind;
    assign status.last       = last_reg;
    assign status.pb_zero    = (pb_reg == '0);
    assign status.pb_one     = (pb_reg == wbn_pkg::CNT_W'(1));
    assign status.ps_zero    = (ps_reg == '0);
    assign status.replace    = replace_reg;
    assign status.collapse   = collapse_reg;
    assign status.cnt_one    = (cnt_reg == wbn_pkg::CNT_W'(1));
    assign status.emit_ok    = !hold_valid_reg || out_free;
    assign status.release_ok = !hold_valid_reg || out_free;

    `WBN_ASSERT_NOW(a_emit_room, cmd.emit && hold_valid_reg, out_free, "emit over a blocked output")
    `WBN_ASSERT_NEXT(a_release_marks, cmd.release_hold && hold_valid_reg, out_valid_reg && out_last_reg, "released byte not marked last")
    `WBN_ASSERT_NOW(a_run_nonzero, cmd.cnt_dec, cnt_reg != '0, "run count underflow")
    `WBN_ASSERT_NOW(a_count_sat, 1'b1, (ps_reg <= wbn_pkg::MAX_RUN) && (pb_reg <= wbn_pkg::MAX_RUN), "pending count above limit")

endmodule

>>> src/wbn_ctrl.sv
// controller: request intake, per-item operation list and its sequencer
// depends on wbn_pkg; drives wbn_dp through ctrl_cmd_t
module wbn_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  wbn_pkg::dp_status_t status,
    output wbn_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_EXEC,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_END,
        OP_BREAKS,
        OP_SPACES,
        OP_ESCAPE,
        OP_TEXT,
        OP_SET_COLLAPSE,
        OP_SET_REPLACE,
        OP_RESET
    } op_t;

    state_t state_reg, state_next;
    op_t    prog_reg  [wbn_pkg::PROG_LEN];
    op_t    prog_next [wbn_pkg::PROG_LEN];
    op_t    shifted   [wbn_pkg::PROG_LEN];
    logic [2:0] pos;

    always_comb
    begin
        for (int i = 0; i < wbn_pkg::PROG_LEN - 1; i++)
        begin
            shifted[i] = prog_reg[i + 1];
        end
        shifted[wbn_pkg::PROG_LEN - 1] = OP_END;
    end

    always_comb
    begin
        cmd        = '0;
        cmd.emit_sel = wbn_pkg::EM_TEXT;
        state_next = state_reg;
        prog_next  = prog_reg;
        pos        = 3'd0;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                for (int i = 0; i < wbn_pkg::PROG_LEN; i++)
                begin
                    prog_next[i] = OP_END;
                end
                if (status.esc_seen)
                begin
                    cmd.esc_clr = 1'b1;
                    case (status.code_kind) inside
                        wbn_pkg::CK_DOUBLE_ON, wbn_pkg::CK_DOUBLE_OFF:
                        begin
                            cmd.set_double = 1'b1;
                        end
                        wbn_pkg::CK_COLLAPSE_ON, wbn_pkg::CK_COLLAPSE_OFF:
                        begin
                            prog_next[0] = OP_SPACES;
                            prog_next[1] = OP_SET_COLLAPSE;
                            pos          = 3'd2;
                        end
                        wbn_pkg::CK_REPLACE_ON, wbn_pkg::CK_REPLACE_OFF:
                        begin
                            prog_next[0] = OP_BREAKS;
                            prog_next[1] = OP_SET_REPLACE;
                            pos          = 3'd2;
                        end
                        default:
                        begin
                            // unknown code: the pair passes through
                            prog_next[0] = OP_ESCAPE;
                            prog_next[1] = OP_TEXT;
                            pos          = 3'd2;
                        end
                    endcase
                end
                else
                begin
                    unique case (status.byte_kind)
                        wbn_pkg::BK_BREAK:
                        begin
                            cmd.pb_inc   = 1'b1;
                            prog_next[0] = OP_SPACES;
                            pos          = 3'd1;
                        end
                        wbn_pkg::BK_SPACE:
                        begin
                            cmd.ps_add   = 1'b1;
                            prog_next[0] = OP_BREAKS;
                            pos          = 3'd1;
                        end
                        wbn_pkg::BK_ESCAPE:
                        begin
                            cmd.esc_set = 1'b1;
                        end
                        wbn_pkg::BK_TEXT:
                        begin
                            prog_next[0] = OP_BREAKS;
                            prog_next[1] = OP_SPACES;
                            prog_next[2] = OP_TEXT;
                            pos          = 3'd3;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (status.last)
                begin
                    // lone escape at end of stream goes out first
                    if (!status.esc_seen && (status.byte_kind == wbn_pkg::BK_ESCAPE))
                    begin
                        prog_next[pos] = OP_ESCAPE;
                        pos            = pos + 3'd1;
                    end
                    prog_next[pos]        = OP_BREAKS;
                    prog_next[pos + 3'd1] = OP_SPACES;
                    prog_next[pos + 3'd2] = OP_RESET;
                end
                state_next = ST_EXEC;
            end

            ST_EXEC:
            begin
                unique case (prog_reg[0])
                    OP_END:
                    begin
                        state_next = ST_DONE;
                    end
                    OP_BREAKS:
                    begin
                        prog_next = shifted;
                        if (!status.pb_zero)
                        begin
                            if (status.replace && status.pb_one)
                            begin
                                cmd.ps_add = 1'b1;
                                cmd.pb_clr = 1'b1;
                            end
                            else
                            begin
                                cmd.run_load = 1'b1;
                                cmd.run_brk  = 1'b1;
                                cmd.pb_clr   = 1'b1;
                                state_next   = ST_RUN;
                            end
                        end
                    end
                    OP_SPACES:
                    begin
                        if (status.ps_zero)
                        begin
                            prog_next = shifted;
                        end
                        else if (!status.collapse)
                        begin
                            prog_next    = shifted;
                            cmd.run_load = 1'b1;
                            cmd.ps_clr   = 1'b1;
                            state_next   = ST_RUN;
                        end
                        else if (status.emit_ok)
                        begin
                            prog_next    = shifted;
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = wbn_pkg::EM_SPACE;
                            cmd.ps_clr   = 1'b1;
                        end
                    end
                    OP_ESCAPE:
                    begin
                        if (status.emit_ok)
                        begin
                            prog_next    = shifted;
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = wbn_pkg::EM_ESCAPE;
                        end
                    end
                    OP_TEXT:
                    begin
                        if (status.emit_ok)
                        begin
                            prog_next    = shifted;
                            cmd.emit     = 1'b1;
                            cmd.emit_sel = wbn_pkg::EM_TEXT;
                        end
                    end
                    OP_SET_COLLAPSE:
                    begin
                        prog_next        = shifted;
                        cmd.set_collapse = 1'b1;
                    end
                    OP_SET_REPLACE:
                    begin
                        prog_next       = shifted;
                        cmd.set_replace = 1'b1;
                    end
                    OP_RESET:
                    begin
                        prog_next       = shifted;
                        cmd.modes_reset = 1'b1;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_RUN:
            begin
                if (status.emit_ok)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = wbn_pkg::EM_RUN;
                    cmd.cnt_dec  = 1'b1;
                    if (status.cnt_one)
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_DONE:
            begin
                if (status.release_ok)
                begin
                    cmd.release_hold = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < wbn_pkg::PROG_LEN; i++)
            begin
                prog_reg[i] <= OP_END;
            end
        end
        else
        begin
            state_reg <= state_next;
            prog_reg  <= prog_next;
        end
    end

endmodule

>>> src/whitespace_break_normalizer_core.sv
// top level of the whitespace and break normaliser
// depends on wbn_pkg, wbn_ctrl and wbn_dp
//
//   channel   direction  handshake                     payload
//   s_axis    in         s_axis_tvalid/s_axis_tready   tdata = in_byte, tlast = in_last
//   m_axis    out        m_axis_tvalid/m_axis_tready   tdata = out_byte, tlast = out_last
//   cfg       in         cfg_we                        cfg_addr = index, cfg_data = value
//
// one request at a time: accept, dispatch, then each step of the item's operation
// list and each byte of a flushed run in turn, then a final step that marks the
// last byte of the item; the controller's sequencer steps through this order, and
// the single hold stage in front of the output keeps that last byte back
// control state and configuration sit in flip-flops cleared by rst_n; the payload registers are not reset
// m_axis_tready low stalls only the step that needs to pass a byte onward
module whitespace_break_normalizer_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [wbn_pkg::BYTE_W-1:0]     s_axis_tdata,   // [7:0] in_byte
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [wbn_pkg::BYTE_W-1:0]     m_axis_tdata,   // [7:0] out_byte
    output logic                          m_axis_tlast,
    input  logic                          cfg_we,
    input  logic [wbn_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [wbn_pkg::BYTE_W-1:0]     cfg_data
);

    wbn_pkg::ctrl_cmd_t  cmd;
    wbn_pkg::dp_status_t status;

    wbn_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wbn_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
